FILE: design/jog_pendant_input_conditioner_defines.svh
// assertion macros for the jog pendant input conditioner
// clocked on i_clk and disabled while i_rst_n is low; no other dependencies
`ifndef JOG_PENDANT_INPUT_CONDITIONER_DEFINES_SVH
`define JOG_PENDANT_INPUT_CONDITIONER_DEFINES_SVH

// same-cycle implication
`define JPIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JPIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/jpic_pkg.sv
// shared types and constants for the jog pendant input conditioner
// no dependencies; used by jpic_cdiv and the top level
package jpic_pkg;

    // field widths
    localparam int ADC_W   = 12;
    localparam int UPD_W   = 16;
    localparam int DB_W    = 7;
    localparam int FMAX_W  = 16;
    localparam int FEED_W  = 17;
    localparam int NOW_W   = 32;
    localparam int DIR_W   = 3;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;

    // default full-scale reading
    localparam int ADC_FULL_SCALE_DEF = 4095;

    // joystick mapping and feed rounding
    localparam int AXIS_SPAN   = 200;
    localparam int AXIS_SPAN_W = 8;
    localparam int AXIS_OFFSET = 100;
    localparam int FEED_STEP   = 100;

    // register reset values
    localparam logic [UPD_W-1:0]  UPD_RST  = UPD_W'(100);
    localparam logic [DB_W-1:0]   DB_RST   = DB_W'(20);
    localparam logic [FMAX_W-1:0] FMAX_RST = FMAX_W'(5000);

    // register indexes
    localparam logic [CFG_AW-1:0] REG_UPDATE_INTERVAL = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_DEADBAND        = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_FEED_MAX        = CFG_AW'(2);

    // jog directions
    typedef enum logic [DIR_W-1:0] {
        DIR_XP = 3'd0,
        DIR_XM = 3'd1,
        DIR_YP = 3'd2,
        DIR_YM = 3'd3,
        DIR_ZP = 3'd4,
        DIR_ZM = 3'd5
    } t_dir;

    // stage advance controls for a constant divider
    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } t_cdiv_ctl;

endpackage

FILE: design/jpic_cdiv.sv
// two-stage divider by a constant: reciprocal multiply, then one correction step
// depends on jpic_pkg (t_cdiv_ctl)
module jpic_cdiv #(
    parameter int NW  = 28,
    parameter int DIV = 4095,
    parameter int QW  = 16
) (
    input  logic                 i_clk,
    input  jpic_pkg::t_cdiv_ctl  i_ctl,
    input  logic [NW-1:0]        i_num,
    output logic [QW-1:0]        o_quo
);

    localparam longint unsigned RECIP = (64'd1 << NW) / DIV;
    localparam int MW = $clog2(RECIP + 1);
    localparam logic [MW-1:0] RECIP_W = MW'(RECIP);
    localparam logic [NW-1:0] DIV_W   = NW'(DIV);

    logic [NW+MW-1:0] r_nm;
    logic [NW-1:0]    r_num;
    logic [QW-1:0]    r_quo;

    logic [NW-1:0] q_est;
    logic [NW-1:0] rem;
    logic [NW-1:0] n_quo;

    // estimate is the true quotient or one below it
    always_comb begin
        q_est = NW'(r_nm[NW+MW-1:NW]);
        rem   = r_num - NW'(q_est * DIV_W);
        n_quo = q_est + NW'(rem >= DIV_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_a) begin
            r_nm  <= {{MW{1'b0}}, i_num} * {{NW{1'b0}}, RECIP_W};
            r_num <= i_num;
        end
        if (i_ctl.adv_b) begin
            r_quo <= QW'(n_quo);
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: design/jog_pendant_input_conditioner.sv
// jog pendant input conditioner, top level
// depends on jpic_pkg, jpic_cdiv and jog_pendant_input_conditioner_defines.svh
// usage:
//   s_axis carries one sample per item: tdata holds the feed, x and y ADC
//   readings and the ms timestamp, tuser holds the button-release flag
//   m_axis returns exactly one result per sample: tdata holds the rounded
//   feed rate, the jog direction and the axis mode after the sample, tuser
//   holds the feed-valid and move-valid flags
//   i_cfg_we/i_cfg_addr/i_cfg_wdata write update interval, deadband and
//   feed max; write them only while no sample is in flight
// timing:
//   seven register stages; one sample per cycle is sustained while m_axis
//   accepts results; the feed path sets the depth: feed multiply, a
//   two-stage divide by the full-scale value and a two-stage round up to a
//   multiple of 100
// reset: synchronous, active low; clears the pipeline, the update timestamp,
//   the last reported feed and the axis mode, and loads register defaults
// stalls: each stage holds its item while the next one is full and stalled,
//   so empty stages still take new samples while a result waits on m_axis
`include "jog_pendant_input_conditioner_defines.svh"

module jog_pendant_input_conditioner #(
    parameter int ADC_FULL_SCALE = jpic_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [jpic_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [jpic_pkg::CFG_DW-1:0] i_cfg_wdata,
    // sample stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [11:0] feed_adc, [23:12] x_adc, [35:24] y_adc, [67:36] now_ms, [71:68] zero
    input  logic [71:0]                 s_axis_tdata,
    // [0] button_released
    input  logic                        s_axis_tuser,
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [16:0] feed_value, [19:17] move_dir, [20] axis_mode_out, [23:21] zero
    output logic [23:0]                 m_axis_tdata,
    // [0] feed_valid, [1] move_valid
    output logic [1:0]                  m_axis_tuser
);

    localparam int ADC_W   = jpic_pkg::ADC_W;
    localparam int FEED_W  = jpic_pkg::FEED_W;
    localparam int NOW_W   = jpic_pkg::NOW_W;
    localparam int FMAX_W  = jpic_pkg::FMAX_W;
    localparam int DIR_W   = jpic_pkg::DIR_W;
    localparam int FEED_NW = ADC_W + FMAX_W;
    localparam int AXIS_NW = ADC_W + jpic_pkg::AXIS_SPAN_W;
    localparam int AXIS_QW = jpic_pkg::AXIS_SPAN_W;
    localparam int CEIL_QW = FEED_W - $clog2(jpic_pkg::FEED_STEP) + 1;
    localparam int NSTG    = 7;

    // readings above full scale saturate
    localparam logic [ADC_W-1:0] ADC_CLAMP =
        (ADC_FULL_SCALE < (2 ** ADC_W) - 1) ? ADC_W'(ADC_FULL_SCALE) : '1;

    // configuration registers
    logic [jpic_pkg::UPD_W-1:0]  r_upd_ivl;
    logic [jpic_pkg::DB_W-1:0]   r_deadband;
    logic [FMAX_W-1:0]           r_feed_max;

    // pipeline control
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   go;

    // stage payload
    logic [ADC_W-1:0]   r_fadc0;
    logic [ADC_W-1:0]   r_xa [0:2];
    logic [ADC_W-1:0]   r_ya [0:2];
    logic [AXIS_NW-1:0] r_xn;
    logic [AXIS_NW-1:0] r_yn;
    logic               r_rel [0:5];
    logic [NOW_W-1:0]   r_now [0:5];
    logic [FEED_NW-1:0] r_prod;

    // divider results
    logic [FMAX_W-1:0]  feed_raw;
    logic [CEIL_QW-1:0] feed_units;
    logic [AXIS_QW-1:0] x_quo;
    logic [AXIS_QW-1:0] y_quo;
    jpic_pkg::t_cdiv_ctl ctl_feed;
    jpic_pkg::t_cdiv_ctl ctl_mid;

    // decision state
    logic [NOW_W-1:0]  r_last_upd;
    logic [FEED_W-1:0] r_prev_feed;
    logic              r_feed_known;
    logic              r_axis_mode;

    // result register
    logic              r_feed_valid;
    logic [FEED_W-1:0] r_feed_value;
    logic              r_move_valid;
    logic [DIR_W-1:0]  r_move_dir;
    logic              r_mode_out;

    // input clamp
    logic [ADC_W-1:0] n_fadc;
    logic [ADC_W-1:0] n_x;
    logic [ADC_W-1:0] n_y;

    // final-stage decision
    logic                    ld_out;
    logic [FEED_W-1:0]       feed_new;
    logic [NOW_W-1:0]        elapsed;
    logic                    due;
    logic                    feed_chg;
    logic signed [AXIS_QW:0] mx;
    logic signed [AXIS_QW:0] my;
    logic signed [AXIS_QW:0] db_s;
    logic                    x_out;
    logic                    y_out;
    logic                    n_feed_valid;
    logic [FEED_W-1:0]       n_feed_value;
    logic                    n_move_valid;
    jpic_pkg::t_dir          n_move_dir;

    // a stage moves on when it is empty or its successor moves on
    always_comb begin
        go[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            go[k] = !r_v[k] || go[k+1];
        end
    end

    assign s_axis_tready = go[0];
    assign ld_out        = go[6] && r_v[5];

    always_comb begin
        n_fadc = (s_axis_tdata[11:0]  > ADC_CLAMP) ? ADC_CLAMP : s_axis_tdata[11:0];
        n_x    = (s_axis_tdata[23:12] > ADC_CLAMP) ? ADC_CLAMP : s_axis_tdata[23:12];
        n_y    = (s_axis_tdata[35:24] > ADC_CLAMP) ? ADC_CLAMP : s_axis_tdata[35:24];
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd_ivl  <= jpic_pkg::UPD_RST;
            r_deadband <= jpic_pkg::DB_RST;
            r_feed_max <= jpic_pkg::FMAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                jpic_pkg::REG_UPDATE_INTERVAL: r_upd_ivl  <= i_cfg_wdata;
                jpic_pkg::REG_DEADBAND:        r_deadband <= i_cfg_wdata[jpic_pkg::DB_W-1:0];
                jpic_pkg::REG_FEED_MAX:        r_feed_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (go[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_fadc0  <= n_fadc;
            r_xa[0]  <= n_x;
            r_ya[0]  <= n_y;
            r_rel[0] <= s_axis_tuser;
            r_now[0] <= s_axis_tdata[67:36];
        end
        if (go[1]) begin
            r_prod <= {{FMAX_W{1'b0}}, r_fadc0} * {{ADC_W{1'b0}}, r_feed_max};
        end
        for (int k = 1; k < 3; k++) begin
            if (go[k]) begin
                r_xa[k] <= r_xa[k-1];
                r_ya[k] <= r_ya[k-1];
            end
        end
        for (int k = 1; k < 6; k++) begin
            if (go[k]) begin
                r_rel[k] <= r_rel[k-1];
                r_now[k] <= r_now[k-1];
            end
        end
        // scale joystick readings by the span ahead of the divide
        if (go[3]) begin
            r_xn <= AXIS_NW'(r_xa[2]) * AXIS_NW'(jpic_pkg::AXIS_SPAN);
            r_yn <= AXIS_NW'(r_ya[2]) * AXIS_NW'(jpic_pkg::AXIS_SPAN);
        end
    end

    assign ctl_feed = '{adv_a: go[2], adv_b: go[3]};
    assign ctl_mid  = '{adv_a: go[4], adv_b: go[5]};

    // feed_adc * feed_max / full scale
    jpic_cdiv #(.NW(FEED_NW), .DIV(ADC_FULL_SCALE), .QW(FMAX_W)) u_feed_div (
        .i_clk (i_clk),
        .i_ctl (ctl_feed),
        .i_num (r_prod),
        .o_quo (feed_raw)
    );

    // ceil(feed / 100)
    jpic_cdiv #(.NW(FEED_W), .DIV(jpic_pkg::FEED_STEP), .QW(CEIL_QW)) u_ceil_div (
        .i_clk (i_clk),
        .i_ctl (ctl_mid),
        .i_num (FEED_W'(feed_raw) + FEED_W'(jpic_pkg::FEED_STEP - 1)),
        .o_quo (feed_units)
    );

    // joystick x * 200 / full scale
    jpic_cdiv #(.NW(AXIS_NW), .DIV(ADC_FULL_SCALE), .QW(AXIS_QW)) u_x_div (
        .i_clk (i_clk),
        .i_ctl (ctl_mid),
        .i_num (r_xn),
        .o_quo (x_quo)
    );

    // joystick y * 200 / full scale
    jpic_cdiv #(.NW(AXIS_NW), .DIV(ADC_FULL_SCALE), .QW(AXIS_QW)) u_y_div (
        .i_clk (i_clk),
        .i_ctl (ctl_mid),
        .i_num (r_yn),
        .o_quo (y_quo)
    );

    // update decision against the state left by the previous sample
    always_comb begin
        feed_new = FEED_W'(feed_units) * FEED_W'(jpic_pkg::FEED_STEP);
        elapsed  = r_now[5] - r_last_upd;
        due      = elapsed > NOW_W'(r_upd_ivl);
        feed_chg = !r_feed_known || (feed_new != r_prev_feed);
        mx       = $signed({1'b0, x_quo}) - (AXIS_QW + 1)'(jpic_pkg::AXIS_OFFSET);
        my       = $signed({1'b0, y_quo}) - (AXIS_QW + 1)'(jpic_pkg::AXIS_OFFSET);
        db_s     = $signed((AXIS_QW + 1)'(r_deadband));
        x_out    = (mx > db_s) || (mx < -db_s);
        y_out    = (my > db_s) || (my < -db_s);

        n_feed_valid = due && feed_chg;
        n_feed_value = n_feed_valid ? feed_new : '0;
        n_move_valid = 1'b0;
        n_move_dir   = jpic_pkg::DIR_XP;
        if (due) begin
            // x beyond the deadband wins; in z mode it gives no move
            if (x_out) begin
                if (!r_axis_mode) begin
                    n_move_valid = 1'b1;
                    n_move_dir   = (mx < 0) ? jpic_pkg::DIR_XM : jpic_pkg::DIR_XP;
                end
            end else if (y_out) begin
                n_move_valid = 1'b1;
                if (!r_axis_mode) begin
                    n_move_dir = (my < 0) ? jpic_pkg::DIR_YP : jpic_pkg::DIR_YM;
                end else begin
                    n_move_dir = (my < 0) ? jpic_pkg::DIR_ZP : jpic_pkg::DIR_ZM;
                end
            end
        end
    end

    // decision state, updated once per sample as it enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_upd   <= '0;
            r_prev_feed  <= '0;
            r_feed_known <= 1'b0;
            r_axis_mode  <= 1'b0;
        end else if (ld_out) begin
            if (due) begin
                r_last_upd <= r_now[5];
            end
            if (n_feed_valid) begin
                r_prev_feed  <= feed_new;
                r_feed_known <= 1'b1;
            end
            // mode toggles after the move decision
            if (r_rel[5]) begin
                r_axis_mode <= !r_axis_mode;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (go[6]) begin
            r_feed_valid <= n_feed_valid;
            r_feed_value <= n_feed_value;
            r_move_valid <= n_move_valid;
            r_move_dir   <= n_move_dir;
            r_mode_out   <= r_axis_mode ^ r_rel[5];
        end
    end

    assign m_axis_tvalid = r_v[6];
    assign m_axis_tdata  = {3'b000, r_mode_out, r_move_dir, r_feed_value};
    assign m_axis_tuser  = {r_move_valid, r_feed_valid};

    `JPIC_ASSERT_NOW(a_ready_when_out_empty, !r_v[6], s_axis_tready,
        "input stalled while result register is empty")
    `JPIC_ASSERT_NOW(a_feed_zero_unless_valid, r_v[6] && !r_feed_valid,
        r_feed_value == '0, "feed value set without feed valid")
    `JPIC_ASSERT_NOW(a_dir_zero_unless_move, r_v[6] && !r_move_valid,
        r_move_dir == jpic_pkg::DIR_XP, "move direction set without move valid")
    `JPIC_ASSERT_NEXT(a_mode_follows_release, ld_out,
        (r_axis_mode == $past(r_axis_mode ^ r_rel[5])) && (r_mode_out == r_axis_mode),
        "axis mode does not follow button release")

endmodule
